// File: design/bba_pkg.sv
// Package: types and constants shared by the buddy allocator.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int unsigned ArenaBytesDef = 65536;
  localparam int unsigned MinOrder      = 5;
  localparam int unsigned HeaderBytes   = 16;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_ALLOC = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_REFUSED     = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_BAD_ADDR    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic [0:0]  mode;
    logic [15:0] request_bytes;
    logic [15:0] free_offset;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] granted_offset;
    logic [1:0]  status;
  } out_beat_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] order;
  } slot_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_DONE
  } state_t;
endpackage

// File: design/buddy_block_allocator.sv
// Top level: buddy allocator control around the slot table RAM.
//  channel | ports                     | handshake
//  input   | start/busy, in_beat       | taken when start high, busy low
//  result  | out_strobe, out_beat      | one cycle, cannot be held off
//  config  | cfg_valid/ready, cfg_data | taken when both high
// S is the arena slot count; the table is swept over one RAM read port. Allocate: a
// sweep plus a split step per split, or a sweep and then the lowest-free rescan when
// nothing is split. A zero-byte allocate ends at the first slot check, a bad free at
// its slot check. Good free: a buddy read and check per merge step, then the rescan.
// After reset or a config write, a clearing pass over all S slots runs; busy is high
// throughout. Results are shown for one cycle only; the receiver cannot stall.
`timescale 1ns / 1ps
module buddy_block_allocator #(
  parameter int unsigned ARENA_BYTES = bba_pkg::ArenaBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bba_pkg::in_beat_t in_beat,
  output logic              out_strobe,
  output bba_pkg::out_beat_t out_beat,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data
);
  import bba_pkg::*;
  // floor of log2 of the arena size
  localparam int unsigned CapRaw = $clog2(ARENA_BYTES + 1) - 1;
  localparam int unsigned Cap    = (CapRaw > 16) ? 16 : CapRaw;
  localparam int unsigned AW     = Cap - MinOrder;
  localparam int unsigned CW     = AW + 1;

  state_t state_r, state_nxt;
  logic [4:0]  order_r;
  logic [4:0]  eff;
  logic [CW-1:0] nslots, idx_r, idx_nxt, s_r, s_nxt, cnt_r, cnt_nxt;
  logic [CW-1:0] found_r, found_nxt, low_r, low_nxt;
  logic        fnd_r, fnd_nxt, lowv_r, lowv_nxt;
  logic [16:0] need_r;
  logic [4:0]  o_r, o_nxt;
  logic [1:0]  phase_r, phase_nxt; // 0 search, 1 lowest rescan, 2 split or refusal committed
  in_beat_t    req_r;
  out_beat_t   res_r, res_nxt;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  slot_t       wdata, rdata;
  logic [16:0] hsize, ssize;
  logic [CW-1:0] span, bud;
  logic [16:0] start_b;
  logic        merge_stop;

  always_comb begin
    eff = order_r;
    if (eff > 5'(Cap)) eff = 5'(Cap);
    if (eff < 5'(MinOrder)) eff = 5'(MinOrder);
    nslots = CW'(1) << (eff - 5'(MinOrder));
  end

  assign busy      = (state_r != S_IDLE) || out_strobe;
  assign cfg_ready = (state_r == S_IDLE) && !out_strobe && !start;

  bba_slot_ram #(.AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; order_r <= 5'd16; idx_r <= '0; out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_DONE);
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_data; state_r <= S_CLEAR; idx_r <= '0;
      end else begin
        state_r <= state_nxt; idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt; cnt_r <= cnt_nxt; found_r <= found_nxt; fnd_r <= fnd_nxt;
    o_r <= o_nxt; phase_r <= phase_nxt; res_r <= res_nxt;
    low_r <= low_nxt; lowv_r <= lowv_nxt;
    if (start && !busy) begin
      req_r  <= in_beat;
      need_r <= {1'b0, in_beat.request_bytes} + 17'(HeaderBytes);
    end
    if (state_r == S_DONE) out_beat <= res_r;
  end

  // bytes of halves at current order
  assign hsize   = 17'(1) << (o_r - 5'd1);
  assign ssize   = 17'(1) << rdata.order;
  assign span    = CW'(1) << (o_r - 5'(MinOrder));
  assign bud     = s_r ^ span;
  assign start_b = {1'b0, req_r.free_offset} - 17'(HeaderBytes);
  assign merge_stop = (o_r >= eff) || (o_r < 5'(MinOrder)) || (bud >= nslots) ||
                      (rdata.kind != KIND_FREE) || (rdata.order != o_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (idx_r == nslots - CW'(1)) state_nxt = S_IDLE;
      S_IDLE:     if (start && !busy)
                    state_nxt = (in_beat.mode == MODE_FREE) ? S_FREE_RD : S_SCAN_RD;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (phase_r == 2'd0 && req_r.request_bytes == 16'd0) state_nxt = S_DONE;
        else if (idx_r == nslots - CW'(1)) begin
          if (phase_r == 2'd0) state_nxt = S_SPLIT;
          else state_nxt = S_DONE;
        end else state_nxt = S_SCAN_RD;
      end
      S_SPLIT: begin
        if (!fnd_r) state_nxt = S_DONE;
        else if (o_r > 5'(MinOrder) && hsize >= need_r) state_nxt = S_SPLIT;
        // refusal of the last free block, or grant after a split
        else if (phase_r == 2'd2 || cnt_r == CW'(1)) state_nxt = S_DONE;
        else state_nxt = S_SCAN_RD;
      end
      S_FREE_RD:  state_nxt = S_FREE_CHK;
      S_FREE_CHK: state_nxt = (res_r.status != ST_OK || rdata.kind != KIND_ALLOC) ?
                              S_DONE : S_MERGE_RD;
      S_MERGE_RD: state_nxt = S_MERGE_CHK;
      S_MERGE_CHK: state_nxt = merge_stop ? S_SCAN_RD : S_MERGE_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs / datapath
  always_comb begin
    idx_nxt = idx_r; s_nxt = s_r; cnt_nxt = cnt_r; found_nxt = found_r;
    fnd_nxt = fnd_r; o_nxt = o_r; phase_nxt = phase_r; res_nxt = res_r;
    low_nxt = low_r; lowv_nxt = lowv_r;
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = slot_t'{kind: KIND_NONE, order: 5'd0};
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wdata = (idx_r == '0) ? slot_t'{kind: KIND_FREE, order: eff}
                              : slot_t'{kind: KIND_NONE, order: 5'd0};
        idx_nxt = idx_r + CW'(1);
        if (idx_r == nslots - CW'(1)) idx_nxt = '0;
      end
      S_IDLE: begin
        idx_nxt = '0; cnt_nxt = '0; fnd_nxt = 1'b0; phase_nxt = 2'd0;
        lowv_nxt = 1'b0;
        res_nxt = '{granted_offset: 16'd0, status: ST_REFUSED};
      end
      S_SCAN_CHK: begin
        if (rdata.kind == KIND_FREE) begin
          if (phase_r == 2'd0) begin
            cnt_nxt = cnt_r + CW'(1);
            if (!fnd_r && ssize >= need_r) begin
              fnd_nxt = 1'b1; found_nxt = idx_r; o_nxt = rdata.order;
            end
          end else if (!lowv_r) begin
            lowv_nxt = 1'b1; low_nxt = idx_r;
          end
        end
        idx_nxt = idx_r + CW'(1);
        if (idx_r == nslots - CW'(1)) idx_nxt = '0;
      end
      S_SPLIT: begin
        if (fnd_r) begin
          if (o_r > 5'(MinOrder) && hsize >= need_r) begin
            phase_nxt = 2'd2; // committed to split
            o_nxt = o_r - 5'd1;
            we = 1'b1; waddr = AW'(found_r + span[CW-1:0] / 2'd2);
            wdata = '{kind: KIND_FREE, order: o_r - 5'd1};
          end else if (phase_r != 2'd2 && cnt_r == CW'(1)) begin
            res_nxt.status = ST_REFUSED; phase_nxt = 2'd2; fnd_nxt = 1'b0;
          end else begin
            we = 1'b1; waddr = found_r[AW-1:0];
            wdata = '{kind: KIND_ALLOC, order: o_r};
            res_nxt = '{granted_offset: 16'({found_r, 5'd0}) + 16'(HeaderBytes),
                        status: ST_OK};
            phase_nxt = 2'd1; idx_nxt = '0;
          end
        end
      end
      S_FREE_RD: begin
        s_nxt = CW'(start_b[16:5]);
        raddr = start_b[AW+4:5];
        if ({1'b0, req_r.free_offset} < 17'(HeaderBytes) || start_b[4:0] != 5'd0 ||
            start_b[16:5] >= 12'(nslots))
          res_nxt.status = ST_BAD_ADDR;
        else res_nxt.status = ST_OK;
      end
      S_FREE_CHK: begin
        if (res_r.status == ST_OK) begin
          if (rdata.kind == KIND_FREE) res_nxt.status = ST_DOUBLE_FREE;
          else if (rdata.kind != KIND_ALLOC) res_nxt.status = ST_BAD_ADDR;
          else begin
            we = 1'b1; waddr = s_r[AW-1:0];
            wdata = '{kind: KIND_FREE, order: rdata.order};
            o_nxt = rdata.order; phase_nxt = 2'd0;
          end
        end
      end
      S_MERGE_RD: begin
        // lower half takes its grown order while the buddy is read
        raddr = bud[AW-1:0];
        we = 1'b1; waddr = s_r[AW-1:0];
        wdata = '{kind: KIND_FREE, order: o_r};
      end
      S_MERGE_CHK: begin
        if (merge_stop) begin
          phase_nxt = 2'd1; idx_nxt = '0; lowv_nxt = 1'b0;
        end else begin
          // clear upper, grow lower; lower write next via s_r
          we = 1'b1; waddr = (s_r < bud) ? bud[AW-1:0] : s_r[AW-1:0];
          wdata = '{kind: KIND_NONE, order: 5'd0};
          s_nxt = (s_r < bud) ? s_r : bud;
          o_nxt = o_r + 5'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: design/bba_slot_ram.sv
// Slot table: one synchronous RAM with registered read.
`timescale 1ns / 1ps
module bba_slot_ram #(
  parameter int unsigned AW = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bba_pkg::slot_t  wdata,
  input  logic [AW-1:0]   raddr,
  output bba_pkg::slot_t  rdata
);
  import bba_pkg::*;
  slot_t mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/bba_checker.sv
// Port checker for the buddy allocator, bound to the top level.
`timescale 1ns / 1ps
module bba_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input bba_pkg::out_beat_t out_beat,
  input logic               cfg_valid,
  input logic               cfg_ready
);
  import bba_pkg::*;
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held");
  a_busy_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy) else $error("no clearing pass after config");
  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_beat.status != ST_OK) |-> out_beat.granted_offset == 16'd0)
    else $error("offset on failure");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("cfg ready while busy");
endmodule

bind buddy_block_allocator bba_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_beat(out_beat), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// File: verif/buddy_block_allocator_tb.sv
// Testbench for the buddy block allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int unsigned SLOTS_MAX  = 2048;
  localparam int unsigned MIN_BLOCK  = 32;
  localparam int unsigned IDLE_LIMIT = 100000;
  localparam int unsigned CFG_ARENA_ORDER = 0;

  // Buddy allocator predictor plus store of expected result beats
  class alloc_scoreboard;
    kind_t       kind_tab [SLOTS_MAX];
    logic [4:0]  order_tab[SLOTS_MAX];
    logic [4:0]  arena_order;
    out_beat_t   expected_q[$];
    logic [15:0] live_offsets[$];
    logic [15:0] last_freed;
    int unsigned mismatches;

    function new();
      mismatches = 0;
      last_freed = 16'd16;
      set_order(5'd16);
    endfunction

    function int unsigned eff_order();
      int unsigned o;
      o = arena_order;
      if (o > 16) o = 16;
      if (o < MinOrder) o = MinOrder;
      return o;
    endfunction

    function int unsigned slot_count();
      return (1 << eff_order()) / MIN_BLOCK;
    endfunction

    // register write re-initialises the arena
    function void set_order(logic [4:0] v);
      arena_order = v;
      foreach (kind_tab[i]) begin
        kind_tab[i] = KIND_NONE;
        order_tab[i] = '0;
      end
      kind_tab[0] = KIND_FREE;
      order_tab[0] = 5'(eff_order());
      live_offsets.delete();
    endfunction

    function status_t alloc_block(int unsigned req, output logic [15:0] grant);
      int unsigned need, n, found, o, nfree;
      bit splits;
      grant = '0;
      if (req == 0) return ST_REFUSED;
      need = req + HeaderBytes;
      n = slot_count();
      found = n;
      nfree = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (kind_tab[i] == KIND_FREE) begin
          nfree++;
          if (found == n && (1 << order_tab[i]) >= need) found = i;
        end
      end
      if (found >= n) return ST_REFUSED;
      o = order_tab[found];
      splits = o > MinOrder && (1 << (o - 1)) >= need;
      if (!splits && nfree == 1) return ST_REFUSED;
      while (o > MinOrder && (1 << (o - 1)) >= need) begin
        o--;
        if (found + (1 << o) / MIN_BLOCK < n) begin
          kind_tab[found + (1 << o) / MIN_BLOCK] = KIND_FREE;
          order_tab[found + (1 << o) / MIN_BLOCK] = 5'(o);
        end
      end
      order_tab[found] = 5'(o);
      kind_tab[found] = KIND_ALLOC;
      grant = 16'(found * MIN_BLOCK + HeaderBytes);
      return ST_OK;
    endfunction

    function status_t free_block(int unsigned off);
      int unsigned s, n, o, b, lo, hi, top;
      if (off < HeaderBytes) return ST_BAD_ADDR;
      if ((off - HeaderBytes) % MIN_BLOCK != 0) return ST_BAD_ADDR;
      s = (off - HeaderBytes) / MIN_BLOCK;
      n = slot_count();
      if (s >= n) return ST_BAD_ADDR;
      if (kind_tab[s] == KIND_FREE) return ST_DOUBLE_FREE;
      if (kind_tab[s] != KIND_ALLOC) return ST_BAD_ADDR;
      kind_tab[s] = KIND_FREE;
      top = eff_order();
      forever begin
        o = order_tab[s];
        if (o >= top || o < MinOrder) break;
        b = s ^ ((1 << o) / MIN_BLOCK);
        if (b >= n || kind_tab[b] != KIND_FREE || order_tab[b] != o) break;
        lo = (s < b) ? s : b;
        hi = (s < b) ? b : s;
        kind_tab[hi] = KIND_NONE;
        order_tab[hi] = '0;
        kind_tab[lo] = KIND_FREE;
        order_tab[lo] = 5'(o + 1);
        s = lo;
      end
      return ST_OK;
    endfunction

    function void note_request(in_beat_t b);
      out_beat_t e;
      logic [15:0] g;
      e = '0;
      if (b.mode == MODE_ALLOC) begin
        e.status = alloc_block(b.request_bytes, g);
        e.granted_offset = g;
        if (e.status == ST_OK) live_offsets.push_back(g);
      end else begin
        e.status = free_block(b.free_offset);
        if (e.status == ST_OK) begin
          foreach (live_offsets[i])
            if (live_offsets[i] == b.free_offset) begin
              live_offsets.delete(i);
              break;
            end
          last_freed = b.free_offset;
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: offset %0d status %0d", r.granted_offset, r.status);
        return;
      end
      e = expected_q.pop_front();
      if (r.granted_offset !== e.granted_offset || r.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: offset exp %0d got %0d, status exp %0d got %0d",
                   e.granted_offset, r.granted_offset, e.status, r.status);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_beat_t   in_beat = '0;
  logic       out_strobe;
  out_beat_t  out_beat;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 0;

  always #1 clk = ~clk;

  buddy_block_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_strobe(out_strobe),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_beat);
      if (out_strobe || (start && !busy) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_beat(in_beat_t b);
    in_beat <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(b);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_req(bit m, int unsigned req, int unsigned off);
    in_beat_t b;
    b.mode = m ? MODE_FREE : MODE_ALLOC;
    b.request_bytes = 16'(req);
    b.free_offset = 16'(off);
    send_beat(b);
  endtask

  // hold off until every expected beat has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_order(logic [4:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_order(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beats(int unsigned count);
    in_beat_t b;
    int unsigned arena, pick;
    for (int unsigned k = 0; k < count; k++) begin
      arena = 1 << sb.eff_order();
      b.request_bytes = 16'($urandom);
      b.free_offset = 16'($urandom);
      pick = $urandom_range(99);
      if (sb.live_offsets.size() != 0 && pick < 40) begin
        b.mode = MODE_FREE;
        b.free_offset = sb.live_offsets[$urandom_range(sb.live_offsets.size() - 1)];
      end else if (pick < 85) begin
        b.mode = MODE_ALLOC;
        if (pick < 75) b.request_bytes = 16'($urandom_range(1, arena / 4));
        else if (pick < 82) b.request_bytes = 16'($urandom_range(1, arena));
      end else if (pick < 92) begin
        b.mode = MODE_FREE;
        b.free_offset = sb.last_freed;
      end else begin
        b.mode = mode_t'($urandom_range(1));
        if (pick < 95) b.request_bytes = '0;
        else if (pick < 97) b.free_offset = 16'($urandom_range(arena / MIN_BLOCK) * MIN_BLOCK + 16);
      end
      send_beat(b);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // full arena after reset: refusals, grants, bad and double frees
    send_req(0, 0, 16'hFFFF);
    send_req(0, 16'hFFFF, 0);
    send_req(0, 65520, 0);
    send_req(0, 1, 0);
    send_req(0, 16, 0);
    send_req(1, 0, 16);
    send_req(1, 0, 16);
    send_req(1, 16'hFFFF, 0);
    send_req(1, 0, 17);
    send_req(1, 0, 16'hFFFF);
    send_req(1, 0, 16'hFFF0);
    send_req(1, 0, 48);

    // out-of-range order clamps to the top
    write_order(5'd31);
    send_req(0, 32767, 0);
    send_req(0, 32752, 0);
    send_req(1, 0, 16);

    // below minimum acts as one minimum block: nothing can be granted
    write_order(5'd3);
    gap_pct = 8;
    send_req(0, 1, 0);
    send_req(1, 0, 16);
    random_beats(20);

    write_order(5'd6);
    random_beats(50);
    write_order(5'd8);
    random_beats(100);
    gap_pct = 56;
    drain();
    random_beats(50);
    write_order(5'd10);
    random_beats(100);
    gap_pct = 0;
    write_order(5'd12);
    random_beats(60);
    write_order(5'd7);
    random_beats(40);

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/bba_pkg.sv
design/bba_slot_ram.sv
design/buddy_block_allocator.sv
design/bba_checker.sv
verif/buddy_block_allocator_tb.sv
